@@ sv/wbss_pkg.sv @@
`timescale 1ns / 1ps

package wbss_pkg;

  // signature store capacity
  localparam int MAX_PATTERN = 64;

  // address width of the signature and window stores
  localparam int PAT_AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  // width of the signature length, which can reach MAX_PATTERN itself
  localparam int LEN_W  = $clog2(MAX_PATTERN + 1);
  localparam int OFS_W  = 32;

  // result payload: hit, start, count, first, found, dropped
  localparam int OUT_BITS = 1 + 3 * OFS_W + 2;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  // request selector
  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_TEXT   = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FIN
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic step;
    logic finish;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic text_op;
    logic eligible;
    logic last_step;
    logic out_free;
  } dp_stat_t;

  // circular increment over the store depth
  function automatic logic [PAT_AW-1:0] wrap_inc(input logic [PAT_AW-1:0] a);
    logic [PAT_AW-1:0] res;
    if (a == PAT_AW'(MAX_PATTERN - 1)) begin
      res = '0;
    end else begin
      res = a + 1'b1;
    end
    return res;
  endfunction

endpackage

@@ sv/wbss_ram.sv @@
`timescale 1ns / 1ps

module wbss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/wbss_ctrl.sv @@
`timescale 1ns / 1ps

module wbss_ctrl
  import wbss_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  dp_stat_t   stat,
  output ctrl_cmd_t  cmd
);

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt  = state_r;
    in_tready  = 1'b0;
    cmd        = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready  = stat.out_free;
        cmd.accept = in_tvalid & stat.out_free;
        if (cmd.accept && stat.text_op) begin
          state_nxt = stat.eligible ? ST_SCAN : ST_FIN;
        end
      end
      ST_SCAN: begin
        cmd.step = 1'b1;
        if (stat.last_step) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

@@ sv/wbss_dp.sv @@
`timescale 1ns / 1ps

module wbss_dp
  import wbss_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [7:0]       in_tdata,
  input  logic [2:0]       in_tuser,
  input  logic             in_tlast,
  input  ctrl_cmd_t        cmd,
  output dp_stat_t         stat,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,
  output logic             out_tlast
);

  op_t               op;
  logic [LEN_W-1:0]  pat_len_r, pat_len_nxt;
  logic [PAT_AW-1:0] head_r, head_nxt, head_inc;
  logic [OFS_W-1:0]  ofs_r, ofs_nxt, cnt_r, cnt_nxt, first_r, first_nxt;
  logic              found_r, found_nxt;
  logic [LEN_W-1:0]  k_r, k_nxt;
  logic [PAT_AW-1:0] wa_r, wa_nxt, start_addr;
  logic              rd_v_r, mism_r, mism_nxt, elig_r, elig_nxt, eot_r, eot_nxt;
  logic              out_tvalid_r, out_tvalid_nxt, out_tlast_r;
  logic [OUT_W-1:0]  out_tdata_r;
  logic              out_load, out_free;
  logic [OFS_W-1:0]  ofs_v, cnt_v, first_v, o_start, len_m1;
  logic              found_v, o_hit, o_done, o_drop, hit;
  logic [LEN_W:0]    hx, bx, ax;
  logic [8:0]        pat_rd;
  logic [7:0]        win_rd;
  logic              pat_we, win_we;

  assign op       = op_t'(in_tuser[1:0]);
  assign head_inc = wrap_inc(head_r);
  assign len_m1   = OFS_W'(pat_len_r) - OFS_W'(1);
  assign out_free = !out_tvalid_r || out_tready;

  // window address of the oldest byte the signature covers
  always_comb begin
    hx = (LEN_W + 1)'(head_inc);
    bx = (LEN_W + 1)'(pat_len_r) - (LEN_W + 1)'(1);
    if (hx >= bx) begin
      ax = hx - bx;
    end else begin
      ax = hx + (LEN_W + 1)'(MAX_PATTERN) - bx;
    end
    start_addr = ax[PAT_AW-1:0];
  end

  // status to the controller
  always_comb begin
    stat.text_op   = (op == OP_TEXT);
    stat.eligible  = (pat_len_r != '0) && (ofs_r >= len_m1);
    stat.last_step = (LEN_W'(k_r + 1'b1) == pat_len_r);
    stat.out_free  = out_free;
  end

  assign pat_we = cmd.accept && (op == OP_APPEND) && (pat_len_r < LEN_W'(MAX_PATTERN));
  assign win_we = cmd.accept && (op == OP_TEXT);

  // signature store: wildcard flag over literal byte
  wbss_ram #(
    .WIDTH (9),
    .DEPTH (MAX_PATTERN)
  ) u_pat_ram (
    .clk   (clk),
    .we    (pat_we),
    .waddr (pat_len_r[PAT_AW-1:0]),
    .wdata ({in_tuser[2], in_tdata}),
    .raddr (k_r[PAT_AW-1:0]),
    .rdata (pat_rd)
  );

  // circular window of recent text bytes
  wbss_ram #(
    .WIDTH (8),
    .DEPTH (MAX_PATTERN)
  ) u_win_ram (
    .clk   (clk),
    .we    (win_we),
    .waddr (head_inc),
    .wdata (in_tdata),
    .raddr (wa_r),
    .rdata (win_rd)
  );

  // next state of the scan and result assembly
  always_comb begin
    pat_len_nxt = pat_len_r;
    head_nxt    = head_r;
    k_nxt       = k_r;
    wa_nxt      = wa_r;
    mism_nxt    = mism_r;
    elig_nxt    = elig_r;
    eot_nxt     = eot_r;
    ofs_v       = ofs_r;
    cnt_v       = cnt_r;
    first_v     = first_r;
    found_v     = found_r;
    out_load    = 1'b0;
    o_hit       = 1'b0;
    o_start     = '0;
    o_done      = 1'b0;
    o_drop      = 1'b0;
    hit         = elig_r && !mism_r;

    // compare one entry per cycle as read data comes back
    if (rd_v_r && !pat_rd[8] && (pat_rd[7:0] != win_rd)) begin
      mism_nxt = 1'b1;
    end

    if (cmd.accept) begin
      unique case (op)
        OP_CLEAR: begin
          pat_len_nxt = '0;
          ofs_v       = '0;
          cnt_v       = '0;
          first_v     = '0;
          found_v     = 1'b0;
          out_load    = 1'b1;
        end
        OP_APPEND: begin
          if (pat_len_r < LEN_W'(MAX_PATTERN)) begin
            pat_len_nxt = pat_len_r + 1'b1;
          end else begin
            o_drop = 1'b1;
          end
          out_load = 1'b1;
        end
        OP_TEXT: begin
          head_nxt = head_inc;
          k_nxt    = '0;
          wa_nxt   = start_addr;
          mism_nxt = 1'b0;
          elig_nxt = stat.eligible;
          eot_nxt  = in_tlast;
        end
        default: begin
          out_load = 1'b1;
        end
      endcase
    end

    if (cmd.step) begin
      k_nxt  = k_r + 1'b1;
      wa_nxt = wrap_inc(wa_r);
    end

    // close out a text byte
    if (cmd.finish) begin
      if (hit) begin
        o_hit   = 1'b1;
        o_start = ofs_r - len_m1;
        if (cnt_r != '1) begin
          cnt_v = cnt_r + 1'b1;
        end
        if (!found_r) begin
          found_v = 1'b1;
          first_v = o_start;
        end
      end
      if (ofs_r != '1) begin
        ofs_v = ofs_r + 1'b1;
      end
      o_done   = eot_r;
      out_load = 1'b1;
    end

    // end of text drops the scan counters after reporting them
    if (cmd.finish && eot_r) begin
      ofs_nxt   = '0;
      cnt_nxt   = '0;
      first_nxt = '0;
      found_nxt = 1'b0;
    end else begin
      ofs_nxt   = ofs_v;
      cnt_nxt   = cnt_v;
      first_nxt = first_v;
      found_nxt = found_v;
    end

    if (out_load) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end else begin
      out_tvalid_nxt = out_tvalid_r;
    end
  end

  // control and counter registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_len_r    <= '0;
      head_r       <= '0;
      ofs_r        <= '0;
      cnt_r        <= '0;
      first_r      <= '0;
      found_r      <= 1'b0;
      rd_v_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      pat_len_r    <= pat_len_nxt;
      head_r       <= head_nxt;
      ofs_r        <= ofs_nxt;
      cnt_r        <= cnt_nxt;
      first_r      <= first_nxt;
      found_r      <= found_nxt;
      rd_v_r       <= cmd.step;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // scan working registers and result payload
  always_ff @(posedge clk) begin
    k_r    <= k_nxt;
    wa_r   <= wa_nxt;
    mism_r <= mism_nxt;
    elig_r <= elig_nxt;
    eot_r  <= eot_nxt;
    if (out_load) begin
      out_tdata_r <= {(OUT_W - OUT_BITS)'(0), o_drop, found_v,
                      (found_v ? first_v : OFS_W'(0)), cnt_v, o_start, o_hit};
      out_tlast_r <= o_done;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

endmodule

@@ sv/wildcard_byte_signature_scan_core.sv @@
`timescale 1ns / 1ps

// Wildcard byte signature scanner.
// Input stream: in_tuser selects the request (clear, append signature entry,
// text byte) and carries the wildcard flag of an appended entry; in_tdata holds
// the literal or text byte; in_tlast marks the last byte of a text.
// Output stream: one result per request. out_tdata holds the match flag, the
// match start offset, the saturating match count, the first match offset, the
// found flag and the load-dropped flag; out_tlast echoes the end of text.
// Clear and append requests produce their result at the clock edge that takes
// them, one request per cycle while the receiver takes each result. A text
// byte, when the signature has n > 0 entries and at least n bytes of the scan
// have been seen, is taken and then compared entry by entry, since the
// signature store and the byte window each give one read per cycle; the
// compare is then finished and the result registered. Otherwise a text byte
// is taken and its result registered. One request is in flight at a time.
// A result stays in the output register until taken; while the receiver stalls
// no new request is taken. Reset empties the signature and the scan counters.
module wildcard_byte_signature_scan_core
  import wbss_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,   // byte_value
  input  logic [2:0]       in_tuser,   // op[1:0], wildcard_req[2]
  input  logic             in_tlast,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,  // match_here, match_start, match_count,
                                       // first_match_res, found_any, load_dropped
  output logic             out_tlast
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // request sequencing
  wbss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // stores, counters and result register
  wbss_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

@@ tb/tb_wildcard_byte_signature_scan_core.sv @@
`timescale 1ns / 1ps

module tb_wildcard_byte_signature_scan_core;
  import wbss_pkg::*;

  // selector value with no defined action
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // cycles to let pass after the last result, above the slowest text request
  localparam int SETTLE_CYCLES = MAX_PATTERN + 16;

  typedef struct packed {
    logic        match_here;
    logic [31:0] match_start;
    logic [31:0] match_count;
    logic [31:0] first_match_res;
    logic        found_any;
    logic        scan_done;
    logic        load_dropped;
  } scan_result_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [7:0]       in_tdata = '0;   // byte_value
  logic [2:0]       in_tuser = '0;   // op[1:0], wildcard_req[2]
  logic             in_tlast = 1'b0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;       // match_here, match_start, match_count,
                                     // first_match_res, found_any, load_dropped
  logic             out_tlast;

  // signature and scan state of the predictor
  logic [7:0]   sig_byte [MAX_PATTERN];
  logic         sig_wild [MAX_PATTERN];
  int unsigned  sig_len = 0;
  logic [7:0]   win_byte [MAX_PATTERN];
  int unsigned  win_head = 0;
  logic [31:0]  text_pos = '0;
  logic [31:0]  hit_total = '0;
  logic [31:0]  first_pos = '0;
  logic         seen_hit = 1'b0;

  scan_result_t expected_q [$];
  int           fail_cnt = 0;
  int unsigned  req_total = 0;
  logic         gaps_on = 1'b1;
  int           stall_left = 0;

  wildcard_byte_signature_scan_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  // window and counters back to zero, signature kept
  function automatic void clear_scan();
    foreach (win_byte[i]) win_byte[i] = '0;
    win_head  = 0;
    text_pos  = '0;
    hit_total = '0;
    first_pos = '0;
    seen_hit  = 1'b0;
  endfunction

  // advance the predictor by one request and queue the result it gives
  function automatic void predict_scan(logic [1:0] op, logic [7:0] bval, logic wild,
                                       logic eot);
    scan_result_t r;
    logic         hit;
    int unsigned  idx;
    r = '0;
    case (op)
      OP_CLEAR: begin
        sig_len = 0;
        clear_scan();
      end
      OP_APPEND: begin
        if (sig_len < MAX_PATTERN) begin
          sig_byte[sig_len] = bval;
          sig_wild[sig_len] = wild;
          sig_len++;
        end else begin
          r.load_dropped = 1'b1;
        end
      end
      OP_TEXT: begin
        win_head = (win_head + 1) % MAX_PATTERN;
        win_byte[win_head] = bval;
        // full match needs a signature and enough bytes in this scan
        hit = (sig_len != 0) && (33'(text_pos) + 33'd1 >= 33'(sig_len));
        for (int j = 0; j < sig_len; j++) begin
          idx = (win_head + MAX_PATTERN - ((sig_len - 1 - j) % MAX_PATTERN)) % MAX_PATTERN;
          if (!sig_wild[j] && win_byte[idx] != sig_byte[j]) hit = 1'b0;
        end
        if (hit) begin
          r.match_here  = 1'b1;
          r.match_start = text_pos - (32'(sig_len) - 32'd1);
          if (hit_total != '1) hit_total++;
          if (!seen_hit) begin
            seen_hit  = 1'b1;
            first_pos = r.match_start;
          end
        end
        if (text_pos != '1) text_pos++;
        r.scan_done = eot;
      end
      default: ;
    endcase
    r.match_count     = hit_total;
    r.first_match_res = seen_hit ? first_pos : '0;
    r.found_any       = seen_hit;
    expected_q.push_back(r);
    if (op == OP_TEXT && eot) clear_scan();
  endfunction

  // mostly bytes from a small set so that signatures hit often
  function automatic logic [7:0] pick_byte();
    logic [7:0] b;
    case ($urandom_range(0, 5))
      0: b = 8'h00;
      1: b = 8'hFF;
      2: b = 8'h5A;
      3: b = 8'hA5;
      default: b = 8'($urandom);
    endcase
    return b;
  endfunction

  // drive one request and wait for the handshake
  task automatic send_req(logic [1:0] op, logic [7:0] bval, logic wild, logic eot);
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'($urandom);
      in_tuser  <= 3'($urandom);
      in_tlast  <= 1'($urandom);
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= bval;
    in_tuser  <= {wild, op};
    in_tlast  <= eot;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_scan(op, bval, wild, eot);
    req_total++;
  endtask

  // hold off requests until every result is back, then let the block settle
  task automatic wait_all_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // reload the signature most of the time, then one text with planted copies
  task automatic run_scan();
    int unsigned plen;
    int unsigned tlen;
    logic [7:0]  text_q [$];
    if (sig_len == 0 || $urandom_range(0, 3) != 0) begin
      send_req(OP_CLEAR, pick_byte(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      plen = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 16) : $urandom_range(1, 4);
      repeat (plen) begin
        send_req(OP_APPEND, pick_byte(), $urandom_range(0, 3) == 0,
                 1'($urandom_range(0, 1)));
      end
    end
    tlen = $urandom_range(1, 30);
    while (text_q.size() < tlen) begin
      if ($urandom_range(0, 2) == 0) begin
        for (int j = 0; j < sig_len; j++) text_q.push_back(sig_wild[j] ? pick_byte() : sig_byte[j]);
      end else begin
        text_q.push_back(pick_byte());
      end
    end
    foreach (text_q[i]) begin
      send_req(OP_TEXT, text_q[i], 1'($urandom_range(0, 1)), i == text_q.size() - 1);
    end
  endtask

  // empty signature never hits, unused selector only reports counters
  task automatic test_empty_signature();
    send_req(OP_TEXT, 8'h00, 1'b0, 1'b0);
    send_req(OP_TEXT, 8'hFF, 1'b1, 1'b0);
    send_req(OP_UNUSED, 8'hA5, 1'b1, 1'b1);
    send_req(OP_TEXT, 8'h3C, 1'b0, 1'b1);
  endtask

  // wildcard in the first position matches any byte, literal 0xFF is a literal
  task automatic test_leading_wildcard();
    send_req(OP_CLEAR, 8'hFF, 1'b1, 1'b1);
    send_req(OP_APPEND, 8'hFF, 1'b1, 1'b0);
    send_req(OP_APPEND, 8'h00, 1'b0, 1'b0);
    send_req(OP_APPEND, 8'hFF, 1'b0, 1'b0);
    send_req(OP_TEXT, 8'h77, 1'b0, 1'b0);
    send_req(OP_TEXT, 8'h00, 1'b0, 1'b0);
    send_req(OP_TEXT, 8'hFF, 1'b0, 1'b0);
    send_req(OP_TEXT, 8'h00, 1'b0, 1'b0);
    send_req(OP_TEXT, 8'h00, 1'b0, 1'b0);
    send_req(OP_TEXT, 8'hFF, 1'b0, 1'b0);
    send_req(OP_UNUSED, 8'h00, 1'b0, 1'b0);
    send_req(OP_TEXT, 8'h12, 1'b0, 1'b1);
  endtask

  // window left from the last text must not complete a match before enough bytes are seen
  task automatic test_short_scan();
    send_req(OP_TEXT, 8'h00, 1'b0, 1'b0);
    send_req(OP_TEXT, 8'hFF, 1'b0, 1'b1);
  endtask

  // signature appended between text bytes is compared over the window
  task automatic test_signature_change_mid_scan();
    send_req(OP_CLEAR, 8'h00, 1'b0, 1'b0);
    send_req(OP_TEXT, 8'h41, 1'b0, 1'b0);
    send_req(OP_APPEND, 8'h41, 1'b0, 1'b1);
    send_req(OP_TEXT, 8'h41, 1'b0, 1'b1);
  endtask

  // fill the store, two refused appends, then a full-length match
  task automatic test_store_capacity();
    gaps_on = 1'b1;
    send_req(OP_CLEAR, 8'h00, 1'b0, 1'b0);
    repeat (MAX_PATTERN + 1) begin
      send_req(OP_APPEND, pick_byte(), $urandom_range(0, 2) == 0, 1'($urandom_range(0, 1)));
    end
    send_req(OP_APPEND, 8'hFF, 1'b1, 1'b0);
    send_req(OP_TEXT, pick_byte(), 1'b0, 1'b0);
    for (int j = 0; j < sig_len; j++) begin
      send_req(OP_TEXT, sig_wild[j] ? pick_byte() : sig_byte[j], 1'b0, j == sig_len - 1);
    end
    send_req(OP_CLEAR, 8'h00, 1'b0, 1'b0);
  endtask

  // mostly well-formed scans, some random requests, some drain pauses
  task automatic test_random_scans(int unsigned stop_at);
    while (req_total < stop_at) begin
      gaps_on = ($urandom_range(0, 9) < 7);
      case ($urandom_range(0, 11))
        0, 1: begin
          repeat ($urandom_range(1, 8)) begin
            send_req(2'($urandom_range(0, 3)),
                     $urandom_range(0, 1) ? pick_byte() : 8'($urandom),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
          end
        end
        2: wait_all_results();
        default: run_scan();
      endcase
    end
  endtask

  // back-to-back requests, the receiver ready once any stall in progress ends
  task automatic test_steady_stream(int unsigned count);
    int unsigned stop_at;
    stop_at = req_total + count;
    gaps_on = 1'b0;
    while (req_total < stop_at) run_scan();
  endtask

  // receiver stalls in bursts while gaps are on
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 13) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      fail_cnt++;
    end
  endfunction

  // compare each taken result with the oldest expectation
  always @(posedge clk) begin
    scan_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_q.size() == 0) begin
        $error("result with no request outstanding: %h", out_tdata);
        fail_cnt++;
      end else begin
        exp_r = expected_q.pop_front();
        check_field("match_here", 32'(exp_r.match_here), 32'(out_tdata[0]));
        check_field("match_start", exp_r.match_start, out_tdata[32:1]);
        check_field("match_count", exp_r.match_count, out_tdata[64:33]);
        check_field("first_match_res", exp_r.first_match_res, out_tdata[96:65]);
        check_field("found_any", 32'(exp_r.found_any), 32'(out_tdata[97]));
        check_field("load_dropped", 32'(exp_r.load_dropped), 32'(out_tdata[98]));
        check_field("scan_done", 32'(exp_r.scan_done), 32'(out_tlast));
      end
    end
  end

  // watchdog
  initial begin
    #(64'd20_000_000);
    $display("Regression FAIL");
    $finish;
  end

  // test sequence
  initial begin
    foreach (win_byte[i]) win_byte[i] = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_empty_signature();
    test_leading_wildcard();
    test_short_scan();
    test_signature_change_mid_scan();
    wait_all_results();
    test_store_capacity();
    test_random_scans(1530);
    test_steady_stream(120);
    wait_all_results();
    if (fail_cnt == 0 && expected_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/wbss_pkg.sv
sv/wbss_ram.sv
sv/wbss_ctrl.sv
sv/wbss_dp.sv
sv/wildcard_byte_signature_scan_core.sv
tb/tb_wildcard_byte_signature_scan_core.sv
